>>> src/bdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

   // Grid size defaults.
   localparam int MAX_WIDTH_DEFAULT  = 128;
   localparam int MAX_HEIGHT_DEFAULT = 128;

   // Stored distance width and its saturation value.
   localparam int          DIST_W   = 8;
   localparam logic [7:0]  DIST_SAT = 8'd255;

   // Gray scale: 15 distance steps span the full display range.
   localparam int          GRAY_LEVELS = 15;
   localparam int          GRAY_STEP   = 255 / GRAY_LEVELS;
   localparam int          GRAY_W      = DIST_W + 5;
   localparam logic [7:0]  GRAY_MAX    = 8'd255;

   // Configuration register map.
   localparam int                     CSR_INDEX_W      = 2;
   localparam int                     CSR_DATA_W       = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_DATA_W-1:0]  DIM_RESET        = 8'd128;

   // Request operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Request and response payloads.
   typedef struct packed {
      logic       operation;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } bdg_req_type;

   typedef struct packed {
      logic [7:0] distance_value;
      logic [7:0] gray_level;
      logic       last_cell;
   } bdg_rsp_type;

   // Sequencer states for the two raster passes.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FWD,
      ST_BWD,
      ST_DRAIN
   } bdg_state_type;

endpackage

`default_nettype wire

>>> src/brushfire_distance_grid.sv
// Loads and reads are accepted only while busy is low, and reads may follow one another in every
// cycle; a computed-grid read returns on rsp_valid through a pending and a result register.
// The final load starts the distance transform: busy stays high while the sequencer steps one
// cell per cycle through the grid memory in a forward pass and a backward pass, then a drain.
// Reset is synchronous: image size returns to 128 by 128, positions and the computed flag clear;
// the grid memory is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module brushfire_distance_grid import bdg_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bdg_req_type            req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output bdg_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CELL_W = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic [COL_W-1:0]      eff_w;
   logic [ROW_W-1:0]      eff_h;
   logic [CELL_W-1:0]     total;

   bdg_state_type state_ff;
   bdg_state_type state_in;
   logic          issue_fwd;
   logic          issue_bwd;

   logic [ADDR_W-1:0] load_pos_ff;
   logic [ADDR_W-1:0] load_pos_in;
   logic [ADDR_W-1:0] read_pos_ff;
   logic [ADDR_W-1:0] read_pos_in;
   logic              computed_ff;
   logic              computed_in;

   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] idx_in;
   logic              idx_last;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s1_vert_ff;
   logic              s1_horz_ff;
   logic [DIST_W-1:0] prev_ff;

   logic              load_accept;
   logic              read_accept;
   logic              read_issue;
   logic              load_wall;
   logic              load_restart;
   logic [ADDR_W-1:0] load_addr;
   logic [CELL_W-1:0] load_next;
   logic              load_done;
   logic              read_last;
   logic              cfg_hit;

   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DIST_W-1:0] ram_wr_data;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr_a;
   logic [ADDR_W-1:0] ram_rd_addr_b;
   logic [DIST_W-1:0] ram_rd_data_a;
   logic [DIST_W-1:0] ram_rd_data_b;

   logic [DIST_W:0]   nb_vert;
   logic [DIST_W:0]   nb_horz;
   logic [DIST_W:0]   nb_near;
   logic [DIST_W-1:0] relaxed;

   logic              rd_pend_ff;
   logic              rd_last_ff;
   logic              rsp_valid_ff;
   bdg_rsp_type       rsp_ff;
   logic [DIST_W-1:0] out_value;
   logic [GRAY_W-1:0] gray_full;

   // Effective image size, clamped to 1..maximum.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = COL_W'(MAX_WIDTH);
      end else begin
         eff_w = COL_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
   end

   assign total = CELL_W'(eff_w) * CELL_W'(eff_h);

   // Request decode.
   assign load_accept = start && !busy && (req_data.operation == OP_LOAD);
   assign read_accept = start && !busy && (req_data.operation == OP_READ);
   assign read_issue  = read_accept && computed_ff;

   // Load addressing: a load after a finished image starts a new one.
   assign load_wall    = (req_data.red | req_data.green | req_data.blue) == 8'd0;
   assign load_restart = computed_ff || (CELL_W'(load_pos_ff) >= total);
   assign load_addr    = load_restart ? '0 : load_pos_ff;
   assign load_next    = CELL_W'(load_addr) + CELL_W'(1);
   assign load_done    = load_next == total;
   assign read_last    = (CELL_W'(read_pos_ff) + CELL_W'(1)) == total;
   assign cfg_hit      = csr_we &&
                         ((csr_index == REG_IMAGE_WIDTH) || (csr_index == REG_IMAGE_HEIGHT));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer next state.
   assign idx_last = idx_ff == ADDR_W'(total - CELL_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (load_accept && load_done) state_in = ST_FWD;
         ST_FWD:   if (idx_last) state_in = ST_BWD;
         ST_BWD:   if (idx_ff == '0) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy      = 1'b1;
      issue_fwd = 1'b0;
      issue_bwd = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy      = 1'b0;
         ST_FWD:   issue_fwd = 1'b1;
         ST_BWD:   issue_bwd = 1'b1;
         ST_DRAIN: ;
         default:  busy      = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Raster position of the cell being issued to the grid memory.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      idx_in = idx_ff;
      if (load_accept && load_done) begin
         row_in = '0;
         col_in = '0;
         idx_in = '0;
      end else if (issue_fwd) begin
         if (idx_last) begin
            row_in = eff_h - ROW_W'(1);
            col_in = eff_w - COL_W'(1);
         end else if (col_ff == eff_w - COL_W'(1)) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if (!idx_last) begin
            idx_in = idx_ff + ADDR_W'(1);
         end
      end else if (issue_bwd) begin
         if (col_ff == '0) begin
            row_in = row_ff - ROW_W'(1);
            col_in = eff_w - COL_W'(1);
         end else begin
            col_in = col_ff - COL_W'(1);
         end
         idx_in = idx_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      idx_ff <= idx_in;
   end

   // Update stage: neighbour flags travel with the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_fwd || issue_bwd;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= idx_ff;
      s1_vert_ff <= issue_fwd ? (row_ff != '0) : (row_ff != eff_h - ROW_W'(1));
      s1_horz_ff <= issue_fwd ? (col_ff != '0) : (col_ff != eff_w - COL_W'(1));
      if (s1_valid_ff) begin
         prev_ff <= relaxed;
      end
   end

   // Relaxation: the border counts as wall; the row neighbour is the cell just updated.
   always_comb begin
      nb_vert = s1_vert_ff ? ({1'b0, ram_rd_data_b} + (DIST_W + 1)'(1)) : (DIST_W + 1)'(1);
      nb_horz = s1_horz_ff ? ({1'b0, prev_ff} + (DIST_W + 1)'(1)) : (DIST_W + 1)'(1);
      nb_near = (nb_vert < nb_horz) ? nb_vert : nb_horz;
      if (ram_rd_data_a == '0) begin
         relaxed = '0;
      end else if (nb_near < {1'b0, ram_rd_data_a}) begin
         relaxed = nb_near[DIST_W-1:0];
      end else begin
         relaxed = ram_rd_data_a;
      end
   end

   // Grid memory ports.
   assign ram_wr_en     = s1_valid_ff || load_accept;
   assign ram_wr_addr   = s1_valid_ff ? s1_idx_ff : load_addr;
   assign ram_wr_data   = s1_valid_ff ? relaxed : (load_wall ? '0 : DIST_SAT);
   assign ram_rd_addr_a = busy ? idx_ff : read_pos_ff;

   always_comb begin
      ram_rd_addr_b = idx_ff;
      if (issue_fwd && (row_ff != '0)) begin
         ram_rd_addr_b = idx_ff - ADDR_W'(eff_w);
      end else if (issue_bwd && (row_ff != eff_h - ROW_W'(1))) begin
         ram_rd_addr_b = idx_ff + ADDR_W'(eff_w);
      end
   end

   bdg_grid_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_grid_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   // Load and read positions; a write to a size register restarts the image.
   always_comb begin
      load_pos_in = load_pos_ff;
      read_pos_in = read_pos_ff;
      computed_in = computed_ff;
      if (load_accept) begin
         if (load_done) begin
            load_pos_in = '0;
            read_pos_in = '0;
            computed_in = 1'b1;
         end else begin
            load_pos_in = ADDR_W'(load_next);
            computed_in = 1'b0;
         end
      end
      if (read_issue) begin
         read_pos_in = read_last ? '0 : read_pos_ff + ADDR_W'(1);
      end
      if (cfg_hit) begin
         load_pos_in = '0;
         read_pos_in = '0;
         computed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         read_pos_ff <= '0;
         computed_ff <= 1'b0;
      end else begin
         load_pos_ff <= load_pos_in;
         read_pos_ff <= read_pos_in;
         computed_ff <= computed_in;
      end
   end

   // Result formatting: stored distance plus one (zero and saturation kept), and the gray level.
   always_comb begin
      if (ram_rd_data_a == '0) begin
         out_value = '0;
      end else if (ram_rd_data_a == DIST_SAT) begin
         out_value = DIST_SAT;
      end else begin
         out_value = ram_rd_data_a + DIST_W'(1);
      end
      gray_full = GRAY_W'(out_value) * GRAY_W'(GRAY_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= read_issue;
         rsp_valid_ff <= rd_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff <= read_last;
      if (rd_pend_ff) begin
         rsp_ff.distance_value <= out_value;
         rsp_ff.gray_level     <= (gray_full > GRAY_W'(GRAY_MAX)) ? GRAY_MAX
                                                                  : gray_full[7:0];
         rsp_ff.last_cell      <= rd_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A result transfer follows an accepted read of a computed grid, through the pending register.
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_data.operation == OP_READ) && computed_ff, 2))
      else $error("result without a matching read");

   // The update stage never shares the write port with a load.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && load_accept))
      else $error("grid write port clash");

   // The passes only start from the final load of an image.
   a_busy_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy && (req_data.operation == OP_LOAD) && load_done))
      else $error("passes started without a final load");
`endif

endmodule

`default_nettype wire

>>> src/bdg_grid_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bdg_grid_ram import bdg_pkg::*; #(
   parameter int DEPTH  = MAX_WIDTH_DEFAULT * MAX_HEIGHT_DEFAULT,
   parameter int ADDR_W = $clog2(MAX_WIDTH_DEFAULT * MAX_HEIGHT_DEFAULT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DIST_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DIST_W-1:0] rd_data_a,
   output logic [DIST_W-1:0] rd_data_b
);

   logic [DIST_W-1:0] mem [DEPTH];
   logic [DIST_W-1:0] q_a_ff;
   logic [DIST_W-1:0] q_b_ff;
   logic [DIST_W-1:0] byp_data_ff;
   logic              byp_a_ff;
   logic              byp_b_ff;

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_a_ff <= mem[rd_addr_a];
      q_b_ff <= mem[rd_addr_b];
   end

   // A read that meets a write to the same entry returns the new data.
   always_ff @(posedge clock) begin
      byp_a_ff    <= wr_en && (wr_addr == rd_addr_a);
      byp_b_ff    <= wr_en && (wr_addr == rd_addr_b);
      byp_data_ff <= wr_data;
   end

   assign rd_data_a = byp_a_ff ? byp_data_ff : q_a_ff;
   assign rd_data_b = byp_b_ff ? byp_data_ff : q_b_ff;

endmodule

`default_nettype wire

>>> verif/brushfire_distance_grid_test.sv
`timescale 1ns / 1ps

module brushfire_distance_grid_test;
   import bdg_pkg::*;

   localparam int GRID_CELLS       = MAX_WIDTH_DEFAULT * MAX_HEIGHT_DEFAULT;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_TRANSFERS = 120;

   // Register indexes outside the map; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   start;
   bdg_req_type            req_data;
   logic                   busy;
   logic                   rsp_valid;
   bdg_rsp_type            rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predicted state of the block.
   logic [7:0]  grid_model [0:GRID_CELLS-1];
   logic [7:0]  width_setting;
   logic [7:0]  height_setting;
   int unsigned next_load_cell;
   int unsigned next_read_cell;
   bit          transform_done;

   bdg_rsp_type expected_cells [$];
   int          mismatch_count    = 0;
   int          cycle_count       = 0;
   int          counted_transfers = 0;
   bit          no_idle           = 1'b0;

   brushfire_distance_grid DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Size in effect for a register value: zero acts as one, large values clamp.
   function automatic int unsigned effective_size(logic [7:0] size_value, int unsigned limit);
      if (size_value == 8'd0) return 1;
      if (size_value > limit) return limit;
      return size_value;
   endfunction

   function automatic int unsigned min_of(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   function automatic int unsigned image_cells();
      return effective_size(width_setting, MAX_WIDTH_DEFAULT) *
             effective_size(height_setting, MAX_HEIGHT_DEFAULT);
   endfunction

   // Exact Manhattan brushfire: a forward raster sweep then a backward one.
   // Cells beyond the grid edge behave as wall.
   function automatic void run_brushfire(int unsigned w, int unsigned h);
      int unsigned idx;
      int unsigned d;
      int unsigned above;
      int unsigned beside;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            idx = r * w + c;
            if (grid_model[idx] != 8'd0) begin
               above  = (r == 0) ? 0 : grid_model[idx - w];
               beside = (c == 0) ? 0 : grid_model[idx - 1];
               d = min_of(grid_model[idx], min_of(above + 1, beside + 1));
               grid_model[idx] = min_of(d, DIST_SAT);
            end
         end
      end
      for (int r = h - 1; r >= 0; r--) begin
         for (int c = w - 1; c >= 0; c--) begin
            idx = r * w + c;
            if (grid_model[idx] != 8'd0) begin
               above  = (r + 1 >= h) ? 0 : grid_model[idx + w];
               beside = (c + 1 >= w) ? 0 : grid_model[idx + 1];
               d = min_of(grid_model[idx], min_of(above + 1, beside + 1));
               grid_model[idx] = min_of(d, DIST_SAT);
            end
         end
      end
   endfunction

   // Advances the predicted state by one accepted request and queues any result.
   function automatic void grid_model_step(bdg_req_type item);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned d;
      int unsigned v;
      int unsigned g;
      bdg_rsp_type predicted;
      w = effective_size(width_setting, MAX_WIDTH_DEFAULT);
      h = effective_size(height_setting, MAX_HEIGHT_DEFAULT);
      total = w * h;
      if (item.operation == OP_LOAD) begin
         if (transform_done || next_load_cell >= total) begin
            transform_done = 1'b0;
            next_load_cell = 0;
         end
         grid_model[next_load_cell] = ((item.red | item.green | item.blue) == 8'd0) ?
                                      8'd0 : DIST_SAT;
         next_load_cell++;
         counted_transfers++;
         if (next_load_cell >= total) begin
            run_brushfire(w, h);
            transform_done = 1'b1;
            next_read_cell = 0;
            next_load_cell = 0;
         end
      end else if (transform_done) begin
         if (next_read_cell >= total) next_read_cell = 0;
         d = grid_model[next_read_cell];
         v = (d == 0) ? 0 : min_of(d + 1, DIST_SAT);
         g = min_of(GRAY_STEP * v, GRAY_MAX);
         predicted.distance_value = v[7:0];
         predicted.gray_level     = g[7:0];
         predicted.last_cell      = (next_read_cell + 1 == total);
         expected_cells.insert(expected_cells.size(), predicted);
         next_read_cell++;
         if (next_read_cell >= total) next_read_cell = 0;
         counted_transfers++;
      end
   endfunction

   // A write to either size register also restarts loading and reading.
   function automatic void size_register_write(logic [CSR_INDEX_W-1:0] index,
                                               logic [CSR_DATA_W-1:0] data);
      if (index == REG_IMAGE_WIDTH) width_setting = data;
      else if (index == REG_IMAGE_HEIGHT) height_setting = data;
      else return;
      next_load_cell = 0;
      next_read_cell = 0;
      transform_done = 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic bdg_req_type make_load(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      bdg_req_type item;
      item.operation = OP_LOAD;
      item.red       = r;
      item.green     = g;
      item.blue      = b;
      return item;
   endfunction

   // Read requests carry random colour channels, which the block ignores.
   function automatic bdg_req_type make_read();
      bdg_req_type item;
      item.operation = OP_READ;
      item.red       = $urandom_range(0, 255);
      item.green     = $urandom_range(0, 255);
      item.blue      = $urandom_range(0, 255);
      return item;
   endfunction

   // Free pixels sometimes have a single live channel, so that each one alone frees a cell.
   function automatic bdg_req_type make_pixel(int unsigned wall_pct);
      bdg_req_type item;
      item = make_load(8'd0, 8'd0, 8'd0);
      if ($urandom_range(0, 99) >= wall_pct) begin
         do begin
            item.red   = $urandom_range(0, 255);
            item.green = $urandom_range(0, 255);
            item.blue  = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     item.green = 8'd0;
                     item.blue  = 8'd0;
                  end
                  1: begin
                     item.red  = 8'd0;
                     item.blue = 8'd0;
                  end
                  default: begin
                     item.red   = 8'd0;
                     item.green = 8'd0;
                  end
               endcase
            end
         end while ((item.red | item.green | item.blue) == 8'd0);
      end
      return item;
   endfunction

   // Sends one request, idling a random number of cycles first, and predicts it on transfer.
   task automatic send_item(input bdg_req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      grid_model_step(item);
   endtask

   task automatic read_cells(input int count);
      repeat (count) send_item(make_read());
   endtask

   task automatic load_image(input int count, input int unsigned wall_pct,
                             input int unsigned noise_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(make_read());
         send_item(make_pixel(wall_pct));
      end
   endtask

   // Holds requests off until every predicted result has arrived and the block is idle.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      size_register_write(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_image_size(input logic [7:0] w_value, input logic [7:0] h_value);
      drain_results();
      csr_write(REG_IMAGE_WIDTH, w_value);
      csr_write(REG_IMAGE_HEIGHT, h_value);
   endtask

   // Reads straight after reset find no computed grid and give nothing back.
   task automatic test_read_before_compute();
      read_cells(2);
   endtask

   // A zero size acts as one: a lone free cell touches the border on all sides.
   // Reads wrap on the single cell, and a further load starts a new image.
   task automatic test_single_cell();
      set_image_size(8'd0, 8'd0);
      send_item(make_load(8'd0, 8'd0, 8'h80));
      read_cells(3);
      send_item(make_load(8'd0, 8'd0, 8'd0));
      read_cells(1);
   endtask

   // One row with each channel freeing a cell on its own; writes to unused indexes
   // must not restart reading, while a size write must.
   task automatic test_single_row();
      set_image_size(8'd5, 8'd1);
      send_item(make_load(8'd0, 8'd0, 8'd0));
      send_item(make_load(8'd1, 8'd0, 8'd0));
      send_item(make_load(8'd0, 8'd1, 8'd0));
      send_item(make_load(8'hFF, 8'hFF, 8'hFF));
      send_item(make_load(8'd0, 8'd0, 8'd1));
      read_cells(2);
      drain_results();
      csr_write(REG_SPARE_2, 8'hFF);
      csr_write(REG_SPARE_3, 8'h5A);
      read_cells(1);
      drain_results();
      csr_write(REG_IMAGE_WIDTH, 8'd5);
      read_cells(1);
   endtask

   // Sizes beyond the maximum clamp; the full width and full height each in one line.
   task automatic test_size_limits();
      set_image_size(8'd255, 8'd0);
      load_image(128, 30, 0);
      read_cells(129);
      set_image_size(8'd1, 8'd128);
      load_image(128, 30, 0);
      read_cells(2);
   endtask

   // A wide open square drives the distance far enough for the gray level to clip.
   task automatic test_gray_saturation();
      set_image_size(8'd29, 8'd29);
      for (int i = 0; i < 29 * 29; i++) begin
         if (i == 0 || i == 29 * 29 - 1) send_item(make_load(8'd0, 8'd0, 8'd0));
         else send_item(make_pixel(0));
      end
      read_cells(425);
   endtask

   function automatic logic [7:0] pick_size_value(bit allow_large);
      case ($urandom_range(0, 15))
         0:       return 8'd0;
         1:       return allow_large ? 8'($urandom_range(129, 255)) : 8'd1;
         2:       return allow_large ? 8'd128 : 8'd2;
         3:       return 8'($urandom_range(9, 12));
         default: return 8'($urandom_range(1, 8));
      endcase
   endfunction

   // Mostly complete images of random size and wall density followed by reads, with
   // stray reads mixed into the loads and now and then an image cut short.
   task automatic test_random_images();
      logic [7:0]  w_value;
      logic [7:0]  h_value;
      int unsigned target;
      int unsigned total;
      int unsigned remaining;
      int unsigned wall_pct;
      bit          first_image;
      target = counted_transfers + RANDOM_TRANSFERS;
      first_image = 1'b1;
      while (counted_transfers < target) begin
         if (first_image || $urandom_range(0, 3) != 0) begin
            w_value = pick_size_value(1'b1);
            if (effective_size(w_value, MAX_WIDTH_DEFAULT) > 12)
               h_value = $urandom_range(0, 2);
            else
               h_value = pick_size_value(effective_size(w_value, MAX_WIDTH_DEFAULT) <= 2);
            set_image_size(w_value, h_value);
         end
         first_image = 1'b0;
         no_idle = ($urandom_range(0, 3) == 0);
         total = image_cells();
         case ($urandom_range(0, 3))
            0:       wall_pct = 0;
            1:       wall_pct = 10;
            2:       wall_pct = 35;
            default: wall_pct = 75;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            load_image($urandom_range(1, total), wall_pct, 10);
            read_cells($urandom_range(1, 3));
         end else begin
            remaining = transform_done ? total : total - next_load_cell;
            load_image(remaining, wall_pct, 5);
            read_cells($urandom_range(1, total + 2));
         end
      end
      no_idle = 1'b0;
   endtask

   // Each result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : result_checker
      bdg_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("result transfer with no read outstanding");
         end else begin
            want = expected_cells.pop_front();
            if (rsp_data.distance_value !== want.distance_value)
               report_mismatch($sformatf("distance_value %0d, expected %0d",
                                         rsp_data.distance_value, want.distance_value));
            if (rsp_data.gray_level !== want.gray_level)
               report_mismatch($sformatf("gray_level %0d, expected %0d",
                                         rsp_data.gray_level, want.gray_level));
            if (rsp_data.last_cell !== want.last_cell)
               report_mismatch($sformatf("last_cell %0b, expected %0b",
                                         rsp_data.last_cell, want.last_cell));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      width_setting  = DIM_RESET;
      height_setting = DIM_RESET;
      next_load_cell = 0;
      next_read_cell = 0;
      transform_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_read_before_compute();
      test_single_cell();
      test_single_row();
      test_size_limits();
      test_gray_saturation();
      test_random_images();

      // Let the last transforms and reads settle before judging.
      drain_results();
      repeat (8) @(posedge clock);
      if (expected_cells.size() != 0)
         report_mismatch($sformatf("%0d predicted results never arrived",
                                   expected_cells.size()));
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/bdg_pkg.sv
src/bdg_grid_ram.sv
src/brushfire_distance_grid.sv
verif/brushfire_distance_grid_test.sv
